// ===== sv/wpb_pkg.sv =====
// Shared constants, microcode encoding and control ROM for window_product_below_count.
// No dependencies; imported by the interfaces, the divider and the top level.
package wpb_pkg;

  localparam int MAX_LEN = 32768;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int IW      = $clog2(MAX_LEN + 1);
  localparam int ELEM_W  = 10;
  localparam int THR_W   = 20;
  localparam int PROD_W  = 30;
  localparam int CNT_W   = 30;
  localparam int DIV_CW  = $clog2(PROD_W + 1);
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [IW-1:0]     MAX_IDX   = IW'(MAX_LEN);
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [DIV_CW-1:0] DIV_STEPS = DIV_CW'(PROD_W);

  // register index (paddr word)
  localparam logic [CFG_AW-3:0] REG_THRESHOLD = '0;

  // sequencer steps
  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE  = 3'd0;
  localparam logic [SW-1:0] S_STORE = 3'd1;
  localparam logic [SW-1:0] S_CHECK = 3'd2;
  localparam logic [SW-1:0] S_POP   = 3'd3;
  localparam logic [SW-1:0] S_DIVW  = 3'd4;
  localparam logic [SW-1:0] S_TAIL  = 3'd5;
  localparam logic [SW-1:0] S_FIN   = 3'd6;
  localparam logic [SW-1:0] S_EMIT  = 3'd7;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LATCH = 3'd1;
  localparam logic [2:0] OP_STORE = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;
  localparam logic [2:0] OP_DIVW  = 3'd5;
  localparam logic [2:0] OP_TAIL  = 3'd6;
  localparam logic [2:0] OP_EMIT  = 3'd7;

  // jump conditions
  localparam logic [2:0] C_ALWAYS   = 3'd0;
  localparam logic [2:0] C_NOIN     = 3'd1;
  localparam logic [2:0] C_FULL     = 3'd2;
  localparam logic [2:0] C_NOSHRINK = 3'd3;
  localparam logic [2:0] C_DZERO    = 3'd4;
  localparam logic [2:0] C_DIVBUSY  = 3'd5;
  localparam logic [2:0] C_NOTLAST  = 3'd6;
  localparam logic [2:0] C_OUTBLK   = 3'd7;

  typedef struct packed {
    logic [2:0]    op;
    logic [2:0]    cond;
    logic [SW-1:0] tgt_t;
    logic [SW-1:0] tgt_f;
  } ucw_t;

  function automatic ucw_t ucode(input logic [SW-1:0] step);
    ucw_t w;
    case (step)
      S_IDLE:  w = '{op: OP_LATCH, cond: C_NOIN,     tgt_t: S_IDLE,  tgt_f: S_STORE};
      S_STORE: w = '{op: OP_STORE, cond: C_FULL,     tgt_t: S_FIN,   tgt_f: S_CHECK};
      S_CHECK: w = '{op: OP_CHECK, cond: C_NOSHRINK, tgt_t: S_TAIL,  tgt_f: S_POP};
      S_POP:   w = '{op: OP_POP,   cond: C_DZERO,    tgt_t: S_CHECK, tgt_f: S_DIVW};
      S_DIVW:  w = '{op: OP_DIVW,  cond: C_DIVBUSY,  tgt_t: S_DIVW,  tgt_f: S_CHECK};
      S_TAIL:  w = '{op: OP_TAIL,  cond: C_ALWAYS,   tgt_t: S_FIN,   tgt_f: S_FIN};
      S_FIN:   w = '{op: OP_NONE,  cond: C_NOTLAST,  tgt_t: S_IDLE,  tgt_f: S_EMIT};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUTBLK,   tgt_t: S_EMIT,  tgt_f: S_IDLE};
      default: w = '{op: OP_NONE,  cond: C_ALWAYS,   tgt_t: S_IDLE,  tgt_f: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/wpb_in_if.sv =====
// Input channel interface: valid/ready transfer of one element and its last mark.
// Depends on wpb_pkg for field widths.
interface wpb_in_if import wpb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              last;

  modport source (output valid, element, last, input ready);
  modport sink   (input valid, element, last, output ready);
endinterface

// ===== sv/wpb_out_if.sv =====
// Result channel interface: valid/ready transfer of the count and overflow flag.
// Depends on wpb_pkg for field widths.
interface wpb_out_if import wpb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count;
  logic             overflow;

  modport source (output valid, count, overflow, input ready);
  modport sink   (input valid, count, overflow, output ready);
endinterface

// ===== sv/wpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/wpb_div.sv =====
// Restoring radix-2 divider: product by one window element, one quotient bit per cycle.
// Depends on wpb_pkg for widths.
module wpb_div import wpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [ELEM_W-1:0] divisor,
  output logic              busy,
  output logic [PROD_W-1:0] quotient
);
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [ELEM_W-1:0] rem_r, rem_nxt;
  logic [ELEM_W-1:0] dsr_r, dsr_nxt;
  logic [ELEM_W:0]   trial;

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;
  assign trial    = {rem_r, quo_r[PROD_W-1]};

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = DIV_STEPS;
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = ELEM_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ELEM_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end
endmodule

// ===== sv/window_product_below_count.sv =====
// window_product_below_count: counts contiguous subarrays whose product is below a threshold.
// Depends on wpb_pkg, wpb_in_if, wpb_out_if, wpb_ram and wpb_div.
//
// Usage:
//   in_s   : one element per transfer; last marks the final element of an array.
//   out_s  : one result (count, overflow) per array, after its last element.
//   cfg_*  : APB write of threshold at byte address 0; reads return it. Write only while idle.
// Timing: a microcoded sequencer handles one element at a time. Each element divided
//   out of the window waits for the divider (a stored zero skips it), and the last
//   element of an array also passes the emit step. The divider, one quotient
//   bit per cycle over 30 bits, sets the pace.
// Elements are held in a 32768 x 10 RAM; elements beyond MAX_LEN are dropped and flagged.
// Reset: step counter, indices, count, flags and threshold clear, the product resets to 1; RAM is not cleared.
// Stall: a result sits in an output register until taken; the next array's
//   elements are still accepted, and only the next result waits for the register.
module window_product_below_count import wpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wpb_in_if.sink            in_s,
  wpb_out_if.source         out_s,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);
  logic [SW-1:0]     step_r, step_nxt;
  logic [ELEM_W-1:0] elem_r, elem_nxt;
  logic              last_r, last_nxt;
  logic [IW-1:0]     right_r, right_nxt;
  logic [IW-1:0]     left_r, left_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  ucw_t              uw;
  logic              cond;
  logic              in_fire, out_blk, full, shrink;
  logic              ram_we;
  logic [ELEM_W-1:0] ram_rdata;
  logic              div_start, div_busy;
  logic [PROD_W-1:0] div_quo;
  logic [IW-1:0]     win_len;
  logic [CNT_W:0]    cnt_sum;
  logic [PROD_W+ELEM_W-1:0] mult;
  logic              cfg_wr, cfg_sel_thr;

  assign uw          = ucode(step_r);
  assign in_s.ready  = (uw.op == OP_LATCH);
  assign in_fire     = in_s.valid && in_s.ready;
  assign out_blk     = out_valid_r && !out_s.ready;
  assign full        = (right_r >= MAX_IDX);
  assign shrink      = (prod_r >= PROD_W'(thr_r)) && (left_r < right_r);
  assign win_len     = right_r - left_r;
  assign cnt_sum     = {1'b0, count_r} + (CNT_W + 1)'(win_len);
  assign mult        = prod_r * elem_r;
  assign ram_we      = (uw.op == OP_STORE) && !full;
  assign div_start   = (uw.op == OP_POP) && (ram_rdata != '0);

  assign out_s.valid    = out_valid_r;
  assign out_s.count    = out_count_r;
  assign out_s.overflow = out_ovf_r;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_thr = (cfg_paddr[CFG_AW-1:2] == REG_THRESHOLD);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_thr ? CFG_DW'(thr_r) : '0;

  wpb_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (right_r[AW-1:0]),
    .wdata (elem_r),
    .raddr (left_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  wpb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (ram_rdata),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   cond = 1'b1;
      C_NOIN:     cond = !in_fire;
      C_FULL:     cond = full;
      C_NOSHRINK: cond = !shrink;
      C_DZERO:    cond = (ram_rdata == '0);
      C_DIVBUSY:  cond = div_busy;
      C_NOTLAST:  cond = !last_r;
      C_OUTBLK:   cond = out_blk;
      default:    cond = 1'b1;
    endcase
    step_nxt = cond ? uw.tgt_t : uw.tgt_f;
  end

  always_comb begin
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    right_nxt     = right_r;
    left_nxt      = left_r;
    prod_nxt      = prod_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    thr_nxt       = cfg_wr && cfg_sel_thr ? cfg_pwdata[THR_W-1:0] : thr_r;
    case (uw.op)
      OP_LATCH: begin
        if (in_fire) begin
          elem_nxt = in_s.element;
          last_nxt = in_s.last;
        end
      end
      OP_STORE: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          right_nxt = right_r + 1'b1;
          prod_nxt  = mult[PROD_W-1:0];
        end
      end
      OP_POP: begin
        left_nxt = left_r + 1'b1;
      end
      OP_DIVW: begin
        if (!div_busy) begin
          prod_nxt = div_quo;
        end
      end
      OP_TAIL: begin
        if (left_r >= right_r) begin
          prod_nxt = PROD_W'(1);
        end
        count_nxt = cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];
      end
      OP_EMIT: begin
        if (!out_blk) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_ovf_nxt   = ovf_r;
          right_nxt     = '0;
          left_nxt      = '0;
          prod_nxt      = PROD_W'(1);
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= S_IDLE;
      right_r     <= '0;
      left_r      <= '0;
      prod_r      <= PROD_W'(1);
      count_r     <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      right_r     <= right_nxt;
      left_r      <= left_nxt;
      prod_r      <= prod_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
    elem_r      <= elem_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

`ifndef ASSERT_OFF
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= right_r)
    else $error("window left index passed right index");

  a_prod_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_IDLE |-> prod_r[PROD_W-1:THR_W] == '0)
    else $error("running product too wide between elements");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> step_r == S_DIVW)
    else $error("divider running outside its wait step");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r == S_EMIT))
    else $error("result raised outside emit step");
`endif
endmodule
